// ===== rtl/core/srit_pkg.sv =====
// Shared constants, types and codes for the sorted record insertion table.
`default_nettype none
package srit_pkg;

  localparam int DEPTH       = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int KEY_FIELD_W = 16;
  localparam int SCORE_W     = 10;
  localparam int KEY_W       = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int REC_W       = KEY_W + 2 * SCORE_W;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_READ = 2'd2
  } status_code_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_FULL,
    ST_EMPTY,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  typedef struct packed {
    logic         take;
    logic         shift;
    logic         place;
    logic         step;
    logic         load;
    status_code_t code;
    logic         rec_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic key_gt;
    logic pos_one;
    logic last_rec;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/srit_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module srit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/srit_datapath.sv =====
// Datapath: record store, count, index, latched beat and result register.
`default_nettype none
module srit_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire srit_pkg::cmd_t             cmd,
  output srit_pkg::sts_t                  sts,
  input  wire logic                       operation,
  input  wire logic [srit_pkg::KEY_FIELD_W-1:0] key_id,
  input  wire logic [srit_pkg::SCORE_W-1:0]     score_a,
  input  wire logic [srit_pkg::SCORE_W-1:0]     score_b,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output logic [1:0]                      status,
  output logic [srit_pkg::KEY_FIELD_W-1:0] out_key,
  output logic [srit_pkg::SCORE_W-1:0]    out_score_a,
  output logic [srit_pkg::SCORE_W-1:0]    out_score_b,
  output logic                            out_valid,
  output logic                            last
);

  logic [srit_pkg::CNT_W-1:0]   count;
  logic [srit_pkg::ADDR_W-1:0]  idx;
  logic                         op_read;
  logic [srit_pkg::REC_W-1:0]   new_rec;
  logic [srit_pkg::REC_W-1:0]   rdata;
  logic [srit_pkg::ADDR_W-1:0]  raddr;
  logic [srit_pkg::REC_W-1:0]   wdata;
  logic                         we;
  logic [srit_pkg::KEY_W-1:0]   rd_key;
  logic [srit_pkg::KEY_W-1:0]   new_key;
  logic [srit_pkg::SCORE_W-1:0] rd_sa;
  logic [srit_pkg::SCORE_W-1:0] rd_sb;

  assign rd_key  = rdata[srit_pkg::REC_W-1 -: srit_pkg::KEY_W];
  assign rd_sa   = rdata[2*srit_pkg::SCORE_W-1 -: srit_pkg::SCORE_W];
  assign rd_sb   = rdata[srit_pkg::SCORE_W-1:0];
  assign new_key = new_rec[srit_pkg::REC_W-1 -: srit_pkg::KEY_W];

  assign raddr = op_read ? idx : idx - srit_pkg::ADDR_W'(1);
  assign we    = cmd.shift | cmd.place;
  assign wdata = cmd.shift ? rdata : new_rec;

  srit_ram #(
    .WIDTH (srit_pkg::REC_W),
    .DEPTH (srit_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.full     = (count == srit_pkg::CNT_W'(srit_pkg::DEPTH));
    sts.empty    = (count == '0);
    sts.key_gt   = (rd_key > new_key);
    sts.pos_one  = (idx == srit_pkg::ADDR_W'(1));
    sts.last_rec = ((srit_pkg::CNT_W'(idx) + srit_pkg::CNT_W'(1)) == count);
    sts.out_free = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.place) begin
        count <= count + srit_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_read <= operation;
      new_rec <= {key_id[srit_pkg::KEY_W-1:0], score_a, score_b};
      idx     <= operation ? '0 : srit_pkg::ADDR_W'(count);
    end else if (cmd.shift) begin
      idx <= idx - srit_pkg::ADDR_W'(1);
    end else if (cmd.step) begin
      idx <= idx + srit_pkg::ADDR_W'(1);
    end
    if (cmd.load) begin
      status      <= cmd.code;
      out_key     <= cmd.rec_sel ? srit_pkg::KEY_FIELD_W'(rd_key) : '0;
      out_score_a <= cmd.rec_sel ? rd_sa : '0;
      out_score_b <= cmd.rec_sel ? rd_sb : '0;
      out_valid   <= cmd.rec_sel;
      last        <= cmd.rec_sel ? sts.last_rec : 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= srit_pkg::CNT_W'(srit_pkg::DEPTH))
    else $error("record count above depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result register overwritten while pending");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (idx != '0 && !cmd.place))
    else $error("shift at slot zero or with place");

  a_place_count: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> count == $past(count) + srit_pkg::CNT_W'(1))
    else $error("count not advanced on insert");

endmodule
`default_nettype wire

// ===== rtl/core/srit_ctrl.sv =====
// Controller: sequences insert shifting and ordered readout.
`default_nettype none
module srit_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           operation,
  input  wire srit_pkg::sts_t sts,
  output srit_pkg::cmd_t      cmd
);

  srit_pkg::state_t state;
  srit_pkg::state_t state_next;
  logic             take;

  assign in_stall = (state != srit_pkg::ST_IDLE);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srit_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srit_pkg::ST_IDLE: begin
        if (take) begin
          if (operation == srit_pkg::OP_READ) begin
            state_next = sts.empty ? srit_pkg::ST_EMPTY : srit_pkg::ST_RD_ADDR;
          end else if (sts.full) begin
            state_next = srit_pkg::ST_FULL;
          end else begin
            state_next = sts.empty ? srit_pkg::ST_INS_WR : srit_pkg::ST_INS_RD;
          end
        end
      end
      srit_pkg::ST_INS_RD: state_next = srit_pkg::ST_INS_CMP;
      srit_pkg::ST_INS_CMP: begin
        if (sts.key_gt && !sts.pos_one) begin
          state_next = srit_pkg::ST_INS_RD;
        end else begin
          state_next = srit_pkg::ST_INS_WR;
        end
      end
      srit_pkg::ST_INS_WR,
      srit_pkg::ST_FULL,
      srit_pkg::ST_EMPTY: begin
        if (sts.out_free) state_next = srit_pkg::ST_IDLE;
      end
      srit_pkg::ST_RD_ADDR: state_next = srit_pkg::ST_RD_DATA;
      srit_pkg::ST_RD_DATA: begin
        if (sts.out_free) begin
          state_next = sts.last_rec ? srit_pkg::ST_IDLE : srit_pkg::ST_RD_ADDR;
        end
      end
      default: state_next = srit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.code    = srit_pkg::STAT_OK;
    cmd.take    = take;
    unique case (state)
      srit_pkg::ST_IDLE: ;
      srit_pkg::ST_INS_RD: ;
      srit_pkg::ST_INS_CMP: cmd.shift = sts.key_gt;
      srit_pkg::ST_INS_WR: begin
        cmd.place = sts.out_free;
        cmd.load  = sts.out_free;
        cmd.code  = srit_pkg::STAT_OK;
      end
      srit_pkg::ST_FULL: begin
        cmd.load = sts.out_free;
        cmd.code = srit_pkg::STAT_FULL;
      end
      srit_pkg::ST_EMPTY: begin
        cmd.load = sts.out_free;
        cmd.code = srit_pkg::STAT_READ;
      end
      srit_pkg::ST_RD_ADDR: ;
      srit_pkg::ST_RD_DATA: begin
        cmd.load    = sts.out_free;
        cmd.step    = sts.out_free && !sts.last_rec;
        cmd.code    = srit_pkg::STAT_READ;
        cmd.rec_sel = 1'b1;
      end
      default: ;
    endcase
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == srit_pkg::ST_IDLE)
    else $error("beat taken outside idle");

  a_shift_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> $past(state) == srit_pkg::ST_INS_RD)
    else $error("shift without a preceding store read");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> in_stall)
    else $error("accepted beat did not leave idle");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_record_insertion_table_unit.sv =====
// Top level of the sorted record insertion table.
//
//  channel | valid     | stall     | fields
//  --------+-----------+-----------+----------------------------------------------------------
//  in      | in_valid  | in_stall  | operation, key_id, score_a, score_b
//  result  | res_valid | res_stall | status, out_key, out_score_a, out_score_b, out_valid, last
//
// One beat is in work at a time; in_stall is high while busy.
// Insert: each record with a greater key is shifted up a slot (store read, compare and write back),
// then the new record is written; an empty table takes it at once and a full table reports full.
// Readout: the records stream out in key order through the registered store read.
// A result register lets a new beat in while the last result waits; res_stall delays loads.
// Reset clears the record count; the store is not cleared.
`default_nettype none
module sorted_record_insertion_table_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             operation,
  input  wire logic [srit_pkg::KEY_FIELD_W-1:0] key_id,
  input  wire logic [srit_pkg::SCORE_W-1:0]     score_a,
  input  wire logic [srit_pkg::SCORE_W-1:0]     score_b,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output logic [1:0]                            status,
  output logic [srit_pkg::KEY_FIELD_W-1:0]      out_key,
  output logic [srit_pkg::SCORE_W-1:0]          out_score_a,
  output logic [srit_pkg::SCORE_W-1:0]          out_score_b,
  output logic                                  out_valid,
  output logic                                  last
);

  srit_pkg::cmd_t cmd;
  srit_pkg::sts_t sts;

  srit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  srit_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .key_id      (key_id),
    .score_a     (score_a),
    .score_b     (score_b),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .out_key     (out_key),
    .out_score_a (out_score_a),
    .out_score_b (out_score_b),
    .out_valid   (out_valid),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== verif/sorted_record_insertion_table_unit_test.sv =====
// Self-checking testbench for the sorted record insertion table.
module sorted_record_insertion_table_unit_test;

  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int DRAIN_CYCLES = 2 * srit_pkg::DEPTH + 16;

  typedef struct {
    srit_pkg::status_code_t               status;
    logic [srit_pkg::KEY_FIELD_W-1:0]     key;
    logic [srit_pkg::SCORE_W-1:0]         score_a;
    logic [srit_pkg::SCORE_W-1:0]         score_b;
    logic                                 valid;
    logic                                 last;
  } table_result_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             operation = 1'b0;
  logic [srit_pkg::KEY_FIELD_W-1:0] key_id    = '0;
  logic [srit_pkg::SCORE_W-1:0]     score_a   = '0;
  logic [srit_pkg::SCORE_W-1:0]     score_b   = '0;
  logic                             res_stall = 1'b0;
  logic                             in_stall;
  logic                             res_valid;
  logic [1:0]                       status;
  logic [srit_pkg::KEY_FIELD_W-1:0] out_key;
  logic [srit_pkg::SCORE_W-1:0]     out_score_a;
  logic [srit_pkg::SCORE_W-1:0]     out_score_b;
  logic                             out_valid;
  logic                             last;

  logic [srit_pkg::KEY_W-1:0]   table_key [srit_pkg::DEPTH];
  logic [srit_pkg::SCORE_W-1:0] table_a   [srit_pkg::DEPTH];
  logic [srit_pkg::SCORE_W-1:0] table_b   [srit_pkg::DEPTH];
  int                           table_fill = 0;

  table_result_t expected_results [$];
  table_result_t oldest_result;
  int            mismatch_count = 0;
  int            result_hold    = 0;
  int            cycle_count    = 0;
  bit            no_gaps        = 1'b0;

  sorted_record_insertion_table_unit DUT (.*);

  always #5 clk = ~clk;

  function automatic int draw_wait();
    if (no_gaps || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [srit_pkg::KEY_FIELD_W-1:0] draw_key();
    case ($urandom_range(0, 3))
      0: return srit_pkg::KEY_FIELD_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return srit_pkg::KEY_FIELD_W'($urandom);
    endcase
  endfunction

  function automatic table_result_t make_result(srit_pkg::status_code_t s,
                                                logic [srit_pkg::KEY_FIELD_W-1:0] k,
                                                logic [srit_pkg::SCORE_W-1:0] a,
                                                logic [srit_pkg::SCORE_W-1:0] b,
                                                logic v, logic l);
    table_result_t r;
    r.status  = s;
    r.key     = k;
    r.score_a = a;
    r.score_b = b;
    r.valid   = v;
    r.last    = l;
    return r;
  endfunction

  task automatic expect_result(table_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v) begin
      $display("mismatch %s: got %0h want %0h at cycle %0d", name, got_v, want_v,
               cycle_count);
      mismatch_count++;
    end
  endtask

  // sorted insert after equal keys; readout streams the table in order
  task automatic predict_table_results(srit_pkg::op_t op,
                                       logic [srit_pkg::KEY_FIELD_W-1:0] key,
                                       logic [srit_pkg::SCORE_W-1:0] a,
                                       logic [srit_pkg::SCORE_W-1:0] b);
    int                         pos;
    logic [srit_pkg::KEY_W-1:0] k;
    k = key[srit_pkg::KEY_W-1:0];
    if (op == srit_pkg::OP_INSERT) begin
      if (table_fill >= srit_pkg::DEPTH) begin
        expect_result(make_result(srit_pkg::STAT_FULL, '0, '0, '0, 1'b0, 1'b1));
      end else begin
        pos = table_fill;
        while (pos > 0 && table_key[pos-1] > k) begin
          table_key[pos] = table_key[pos-1];
          table_a[pos]   = table_a[pos-1];
          table_b[pos]   = table_b[pos-1];
          pos--;
        end
        table_key[pos] = k;
        table_a[pos]   = a;
        table_b[pos]   = b;
        table_fill++;
        expect_result(make_result(srit_pkg::STAT_OK, '0, '0, '0, 1'b0, 1'b1));
      end
    end else if (table_fill == 0) begin
      expect_result(make_result(srit_pkg::STAT_READ, '0, '0, '0, 1'b0, 1'b1));
    end else begin
      for (int i = 0; i < table_fill; i++)
        expect_result(make_result(srit_pkg::STAT_READ,
                                  srit_pkg::KEY_FIELD_W'(table_key[i]),
                                  table_a[i], table_b[i], 1'b1,
                                  i == table_fill - 1));
    end
  endtask

  task automatic send_beat(srit_pkg::op_t op, logic [srit_pkg::KEY_FIELD_W-1:0] key,
                           logic [srit_pkg::SCORE_W-1:0] a,
                           logic [srit_pkg::SCORE_W-1:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key_id    <= key;
    score_a   <= a;
    score_b   <= b;
    do @(posedge clk); while (in_stall);
    predict_table_results(op, key, a, b);
  endtask

  task automatic send_random_insert();
    send_beat(srit_pkg::OP_INSERT, draw_key(), srit_pkg::SCORE_W'($urandom),
              srit_pkg::SCORE_W'($urandom));
  endtask

  task automatic test_empty_readout();
    send_beat(srit_pkg::OP_READ, '1, '1, '1);
  endtask

  task automatic test_directed_order();
    send_beat(srit_pkg::OP_INSERT, 16'h0100, 10'd1, 10'd2);
    send_beat(srit_pkg::OP_INSERT, 16'h0000, 10'd0, 10'd0);
    send_beat(srit_pkg::OP_INSERT, 16'hFFFF, 10'h3FF, 10'h3FF);
    send_beat(srit_pkg::OP_INSERT, 16'h0100, 10'd5, 10'd6);
    send_beat(srit_pkg::OP_INSERT, 16'h0100, 10'h2AA, 10'h155);
    send_beat(srit_pkg::OP_INSERT, 16'h0080, 10'h155, 10'h2AA);
    send_beat(srit_pkg::OP_INSERT, 16'h7FFF, 10'h200, 10'h001);
    send_beat(srit_pkg::OP_INSERT, 16'h8000, 10'h001, 10'h200);
    send_beat(srit_pkg::OP_INSERT, 16'hFFFF, 10'd7, 10'd8);
    send_beat(srit_pkg::OP_READ, 16'h0000, 10'd0, 10'd0);
    send_beat(srit_pkg::OP_INSERT, 16'h0000, 10'd9, 10'd10);
    send_beat(srit_pkg::OP_READ, 16'h5555, 10'h155, 10'h2AA);
    send_beat(srit_pkg::OP_READ, 16'hAAAA, 10'h2AA, 10'h155);
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 100; n++) begin
      if (n % 20 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 55)
        send_random_insert();
      else
        send_beat(srit_pkg::OP_READ, srit_pkg::KEY_FIELD_W'($urandom),
                  srit_pkg::SCORE_W'($urandom), srit_pkg::SCORE_W'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_full_table();
    no_gaps = 1'b1;
    while (table_fill < srit_pkg::DEPTH) begin
      if (table_fill == srit_pkg::DEPTH / 2) no_gaps = 1'b0;
      send_random_insert();
    end
    send_beat(srit_pkg::OP_INSERT, 16'h0000, 10'h000, 10'h000);
    send_beat(srit_pkg::OP_INSERT, 16'hFFFF, 10'h3FF, 10'h3FF);
    send_random_insert();
    send_beat(srit_pkg::OP_READ, '0, '0, '0);
    no_gaps = 1'b1;
    send_beat(srit_pkg::OP_READ, '1, '1, '1);
    send_beat(srit_pkg::OP_INSERT, 16'h8000, 10'h155, 10'h2AA);
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        check_field("result beat with nothing pending", 32'd1, 32'd0);
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("status", status, oldest_result.status);
        check_field("out_key", out_key, oldest_result.key);
        check_field("out_score_a", out_score_a, oldest_result.score_a);
        check_field("out_score_b", out_score_b, oldest_result.score_b);
        check_field("out_valid", out_valid, oldest_result.valid);
        check_field("last", last, oldest_result.last);
      end
      result_hold = draw_wait();
    end
    res_stall <= (result_hold > 0);
    if (result_hold > 0) result_hold--;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_readout();
    test_directed_order();
    test_random_mix();
    test_full_table();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    check_field("results still pending", expected_results.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/srit_pkg.sv
rtl/core/srit_ram.sv
rtl/core/srit_datapath.sv
rtl/core/srit_ctrl.sv
rtl/core/sorted_record_insertion_table_unit.sv
verif/sorted_record_insertion_table_unit_test.sv
